// ===== hdl/aes128_ke_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package aes128_ke_pkg;

  localparam int unsigned IDX_W = 6;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(43);
  localparam logic [7:0] RCON_INIT = 8'h01;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } ke_cmd_t;

  typedef struct packed {
    logic at_last;
    logic out_busy;
  } ke_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [31:0] rot_sub_word(input logic [31:0] x);
    logic [31:0] r;
    r = {x[23:0], x[31:24]};
    return {SBOX[r[31:24]], SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/aes128_ke_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aes128_ke_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  aes128_ke_pkg::ke_status_t status_i,
  output aes128_ke_pkg::ke_cmd_t    cmd_o
);
  import aes128_ke_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!status_i.out_busy) begin
          cmd_o.step = 1'b1;
          if (status_i.at_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/aes128_ke_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aes128_ke_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  aes128_ke_pkg::ke_cmd_t            cmd_i,
  output aes128_ke_pkg::ke_status_t         status_o,
  input  logic [63:0]                       key_high_i,
  input  logic [63:0]                       key_low_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [aes128_ke_pkg::IDX_W-1:0]   word_index_o,
  output logic [31:0]                       round_key_word_o,
  output logic                              last_word_o
);
  import aes128_ke_pkg::*;

  // win_q holds the last four schedule words, oldest in the top word
  logic [127:0]     win_q;
  logic [IDX_W-1:0] idx_q;
  logic [7:0]       rcon_q;
  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [31:0]      out_word_q;
  logic             out_last_q;

  logic             key_phase;
  logic             new_round;
  logic [31:0]      key_word;
  logic [31:0]      temp_word;
  logic [31:0]      next_word;
  logic [31:0]      word;

  assign key_phase = (idx_q[IDX_W-1:2] == '0);
  assign new_round = (idx_q[1:0] == 2'd0);

  always_comb begin
    unique case (idx_q[1:0])
      2'd0:    key_word = win_q[127:96];
      2'd1:    key_word = win_q[95:64];
      2'd2:    key_word = win_q[63:32];
      2'd3:    key_word = win_q[31:0];
      default: key_word = win_q[127:96];
    endcase
  end

  assign temp_word = new_round ? (rot_sub_word(win_q[31:0]) ^ {rcon_q, 24'h000000})
                               : win_q[31:0];
  assign next_word = win_q[127:96] ^ temp_word;
  assign word      = key_phase ? key_word : next_word;

  // the output beat may drain in the same cycle a new key is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (cmd_i.step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      win_q  <= {key_high_i, key_low_i};
      rcon_q <= RCON_INIT;
    end else if (cmd_i.step) begin
      out_idx_q  <= idx_q;
      out_word_q <= word;
      out_last_q <= (idx_q == LAST_IDX);
      if (!key_phase) begin
        win_q <= {win_q[95:0], next_word};
        if (new_round) begin
          rcon_q <= xtime(rcon_q);
        end
      end
    end
  end

  assign status_o.at_last  = (idx_q == LAST_IDX);
  assign status_o.out_busy = out_valid_q & ~out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign word_index_o     = out_idx_q;
  assign round_key_word_o = out_word_q;
  assign last_word_o      = out_last_q;

endmodule
`default_nettype wire

// ===== hdl/aes128_key_expansion_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// AES-128 key schedule. A key beat carries the 128-bit cipher key as two 64-bit halves,
// first key byte in bit 63 of key_high_i. The block answers with 44 beats, w[0] to w[43]
// in order, word_index_o giving the position and last_word_o marking w[43]. One word is
// produced per cycle while the output is not stalled, by a single RotWord/SubWord/Rcon step over
// a four-word sliding window; a stalled output holds the word steps back. in_ready_o is high
// only between keys; the next key is taken as soon as w[43] sits in the output register.
module aes128_key_expansion_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [63:0]                     key_high_i,
  input  logic [63:0]                     key_low_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [aes128_ke_pkg::IDX_W-1:0] word_index_o,
  output logic [31:0]                     round_key_word_o,
  output logic                            last_word_o
);
  import aes128_ke_pkg::*;

  ke_cmd_t    cmd;
  ke_status_t status;

  aes128_ke_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aes128_ke_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .key_high_i       (key_high_i),
    .key_low_i        (key_low_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .word_index_o     (word_index_o),
    .round_key_word_o (round_key_word_o),
    .last_word_o      (last_word_o)
  );

endmodule
`default_nettype wire

// ===== hdl/aes128_ke_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aes128_ke_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [aes128_ke_pkg::IDX_W-1:0] word_index_o,
  input logic [31:0]                     round_key_word_o,
  input logic                            last_word_o
);
  import aes128_ke_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(word_index_o)
      && $stable(round_key_word_o) && $stable(last_word_o))
    else $error("output beat changed while stalled");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == LAST_IDX)))
    else $error("last_word disagrees with word_index");

  a_busy_after_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("key accepted while previous key still expanding");

  a_index_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_word_o |=>
      !out_valid_o || (word_index_o == IDX_W'($past(word_index_o) + IDX_W'(1))))
    else $error("word index skipped or repeated");

  a_no_key_mid_schedule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_word_o |-> !in_ready_o)
    else $error("ready for a key in the middle of a schedule");

endmodule

bind aes128_key_expansion_top aes128_ke_chk u_chk (.*);
`default_nettype wire
